// ===== src/dwsr_pkg.sv =====
// types and constants for the double-ended queue with search and remove
// request codes, status codes, sequencer states and stream packing widths
// no dependencies
package dwsr_pkg;

   // request kinds carried in req_tuser
   typedef enum logic [2:0] {
      OP_PUSH_TAIL = 3'd0,
      OP_PUSH_HEAD = 3'd1,
      OP_POP_HEAD  = 3'd2,
      OP_FIND      = 3'd3,
      OP_REMOVE    = 3'd4,
      OP_CLEAR     = 3'd5
   } op_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_MISS  = 2'd3
   } status_type;

   // sequencer states, one-hot
   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_EXEC     = 7'b0000010,
      S_SCAN_RD  = 7'b0000100,
      S_SCAN_CMP = 7'b0001000,
      S_MOVE_RD  = 7'b0010000,
      S_MOVE_WR  = 7'b0100000,
      S_FINISH   = 7'b1000000
   } state_type;

   // fixed field widths of the stream items
   localparam int unsigned WORD_W  = 32;
   localparam int unsigned POS_W   = 6;
   localparam int unsigned TOTAL_W = 7;
   localparam int unsigned KIND_W  = 3;

   localparam int unsigned REQ_TDATA_W = 40;
   localparam int unsigned RSP_TDATA_W = 56;

endpackage

// ===== src/deque_with_search_and_remove.sv =====
// push, pop, clear and unknown codes pass S_EXEC, then S_FINISH loads the result
// find adds S_SCAN_RD and S_SCAN_CMP per entry inspected, remove adds S_MOVE_RD
// and S_MOVE_WR per entry behind the removed position; one item at a time, the next is
// taken in the cycle after the result is loaded; S_FINISH waits while a result is untaken
// reset: synchronous, active high; clears head index, count, sequencer and result valid
// the entry store itself is not cleared, only live entries are ever read
module deque_with_search_and_remove
   import dwsr_pkg::*;
#(
   parameter int unsigned DEPTH      = 64,
   parameter int unsigned DATA_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // data_value [31:0], position [37:32], zero fill [39:38]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // req_type [2:0]
   input  logic [KIND_W-1:0]      req_tuser,
   // result channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // data_out [31:0], found [32], found_position [38:33], entry_total [45:39],
   // is_empty [46], status [48:47], zero fill [55:49]
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // index width into the ring, count width that can hold DEPTH itself
   localparam int unsigned IW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);
   // width wide enough to compare a request position against the count
   localparam int unsigned PW = ((CW > POS_W) ? CW : POS_W) + 1;

   // sequencer and queue state
   state_type             state_ff, state_in;
   logic [IW-1:0]         head_ff, head_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         idx_ff, idx_in;

   // latched request and result fields
   op_type                op_ff, op_in;
   logic [DATA_WIDTH-1:0] word_ff, word_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   status_type            status_ff, status_in;
   logic                  found_ff, found_in;
   logic [IW-1:0]         fpos_ff, fpos_in;

   // result output register
   logic                   rsp_valid_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_in;
   logic                   rsp_load;

   // ring store, one write and one registered read per cycle
   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic                  mem_we;
   logic                  mem_re;
   logic [IW-1:0]         rd_addr;
   logic [DATA_WIDTH-1:0] wr_data;

   // shared ring index unit: (head + offset) mod DEPTH, offset below DEPTH
   logic [IW-1:0]         ring_off;
   logic [IW:0]           ring_sum;
   logic [IW-1:0]         ring_idx;

   logic [CW-1:0]         idx_nxt;
   logic                  is_full;
   logic                  is_empty;
   logic                  pop_hit;

   assign ring_sum = {1'b0, head_ff} + {1'b0, ring_off};
   assign ring_idx = (ring_sum >= (IW+1)'(DEPTH)) ?
                     IW'(ring_sum - (IW+1)'(DEPTH)) : IW'(ring_sum);

   assign idx_nxt  = idx_ff + CW'(1);
   assign is_full  = (count_ff == CW'(DEPTH));
   assign is_empty = (count_ff == '0);

   assign req_tready = (state_ff == S_IDLE);

   // sequencer
   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      op_in     = op_ff;
      word_in   = word_ff;
      pos_in    = pos_ff;
      status_in = status_ff;
      found_in  = found_ff;
      fpos_in   = fpos_ff;
      ring_off  = '0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      rd_addr   = ring_idx;
      wr_data   = word_ff;
      rsp_load  = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in     = op_type'(req_tuser);
               word_in   = DATA_WIDTH'(req_tdata[WORD_W-1:0]);
               pos_in    = req_tdata[WORD_W+POS_W-1:WORD_W];
               status_in = ST_OK;
               found_in  = 1'b0;
               fpos_in   = '0;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_FINISH;
            case (op_ff)
               OP_PUSH_TAIL: begin
                  ring_off = IW'(count_ff);
                  if (is_full) begin
                     status_in = ST_FULL;
                  end else begin
                     mem_we   = 1'b1;
                     count_in = count_ff + CW'(1);
                  end
               end
               OP_PUSH_HEAD: begin
                  // one step back around the ring
                  ring_off = IW'(DEPTH - 1);
                  if (is_full) begin
                     status_in = ST_FULL;
                  end else begin
                     mem_we   = 1'b1;
                     head_in  = ring_idx;
                     count_in = count_ff + CW'(1);
                  end
               end
               OP_POP_HEAD: begin
                  ring_off = IW'(1);
                  rd_addr  = head_ff;
                  if (is_empty) begin
                     status_in = ST_EMPTY;
                  end else begin
                     mem_re   = 1'b1;
                     head_in  = ring_idx;
                     count_in = count_ff - CW'(1);
                  end
               end
               OP_FIND: begin
                  idx_in = '0;
                  if (is_empty) begin
                     status_in = ST_MISS;
                  end else begin
                     state_in = S_SCAN_RD;
                  end
               end
               OP_REMOVE: begin
                  idx_in = CW'(pos_ff);
                  if (PW'(pos_ff) >= PW'(count_ff)) begin
                     status_in = ST_MISS;
                  end else if (PW'(pos_ff) + PW'(1) < PW'(count_ff)) begin
                     state_in = S_MOVE_RD;
                  end else begin
                     // last entry goes, nothing to close up
                     count_in = count_ff - CW'(1);
                  end
               end
               OP_CLEAR: begin
                  head_in  = '0;
                  count_in = '0;
               end
               default: begin
                  // unused codes report the counts only
               end
            endcase
         end
         S_SCAN_RD: begin
            ring_off = IW'(idx_ff);
            mem_re   = 1'b1;
            state_in = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            if (rd_data_ff == word_ff) begin
               found_in = 1'b1;
               fpos_in  = IW'(idx_ff);
               state_in = S_FINISH;
            end else if (idx_nxt >= count_ff) begin
               status_in = ST_MISS;
               state_in  = S_FINISH;
            end else begin
               idx_in   = idx_nxt;
               state_in = S_SCAN_RD;
            end
         end
         S_MOVE_RD: begin
            // fetch the entry behind the gap
            ring_off = IW'(idx_nxt);
            mem_re   = 1'b1;
            state_in = S_MOVE_WR;
         end
         S_MOVE_WR: begin
            ring_off = IW'(idx_ff);
            mem_we   = 1'b1;
            wr_data  = rd_data_ff;
            idx_in   = idx_nxt;
            if ((CW+1)'(idx_nxt) + (CW+1)'(1) < (CW+1)'(count_ff)) begin
               state_in = S_MOVE_RD;
            end else begin
               count_in = count_ff - CW'(1);
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            // hand over once the output register is free or draining
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result item assembly
   assign pop_hit = (op_ff == OP_POP_HEAD) && (status_ff == ST_OK);

   always_comb begin
      rsp_data_in          = '0;
      rsp_data_in[31:0]    = pop_hit ? WORD_W'(rd_data_ff) : '0;
      rsp_data_in[32]      = found_ff;
      rsp_data_in[38:33]   = POS_W'(fpos_ff);
      rsp_data_in[45:39]   = TOTAL_W'(count_ff);
      rsp_data_in[46]      = is_empty;
      rsp_data_in[48:47]   = status_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      op_ff     <= op_in;
      word_ff   <= word_in;
      pos_ff    <= pos_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      fpos_ff   <= fpos_in;
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // ring store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[ring_idx] <= wr_data;
      end
      if (mem_re) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // count never runs past capacity
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count beyond capacity");

   // head index stays inside the ring
   a_head_bound : assert property (@(posedge clock) disable iff (reset)
      head_ff < IW'(DEPTH - 1) || head_ff == IW'(DEPTH - 1))
      else $error("head index outside ring");

   // an accepted request is executed in the next cycle
   a_accept_exec : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_EXEC))
      else $error("accepted request not executed");

   // a pop of a non-empty queue drops the count by one
   a_pop_count : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && op_ff == OP_POP_HEAD && !is_empty)
      |=> (count_ff == $past(count_ff) - CW'(1)))
      else $error("pop did not drop the count");

   // a result is loaded only when the output slot can take it
   a_no_overrun : assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_valid_ff) |-> rsp_tready)
      else $error("result overwritten before taken");
`endif

endmodule
